/* sv/cdb_pkg.sv */
`default_nettype none
package cdb_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned BUF_W      = 128;
    localparam int unsigned NBITS_W    = 8;
    localparam int unsigned DICT_DEPTH = 8;
    localparam int unsigned DICT_IDX_W = 3;
    localparam int unsigned MAX_RESULTS = 28;
    localparam int unsigned CNT_W      = 5;
    localparam int unsigned Q_DEPTH    = 4;
    localparam int unsigned Q_PTR_W    = 2;

    typedef enum logic [2:0] {
        CODE_REPEAT   = 3'b000,
        CODE_MASK     = 3'b001,
        CODE_FLIP1    = 3'b010,
        CODE_FLIP_ADJ = 3'b011,
        CODE_FLIP2    = 3'b100,
        CODE_DIRECT   = 3'b101,
        CODE_RAW      = 3'b110,
        CODE_STOP     = 3'b111
    } code_t;

    typedef enum logic {
        FE_IDLE,
        FE_DECODE
    } fe_state_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [1:0]        reps;
        logic              last;
    } q_entry_t;

    typedef struct packed {
        logic     push;
        q_entry_t entry;
    } q_push_t;

    function automatic logic [5:0] rec_len(input code_t code);
        logic [5:0] len;
        case (code)
            CODE_REPEAT:   len = 6'd5;
            CODE_MASK:     len = 6'd15;
            CODE_FLIP1:    len = 6'd11;
            CODE_FLIP_ADJ: len = 6'd11;
            CODE_FLIP2:    len = 6'd16;
            CODE_DIRECT:   len = 6'd6;
            CODE_RAW:      len = 6'd35;
            CODE_STOP:     len = 6'd3;
            default:       len = 6'd3;
        endcase
        return len;
    endfunction

    function automatic logic [WORD_W-1:0] bit_at(input logic [4:0] idx);
        return 32'h8000_0000 >> idx;
    endfunction

endpackage
`default_nettype wire

/* sv/cdb_intf.sv */
`default_nettype none
interface cdb_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] stream_word;
    logic        start_of_stream;
    modport source (output valid, output stream_word, output start_of_stream, input ready);
    modport sink (input valid, input stream_word, input start_of_stream, output ready);
endinterface

interface cdb_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction_out;
    logic        last_of_run;
    modport source (output valid, output instruction_out, output last_of_run, input ready);
    modport sink (input valid, input instruction_out, input last_of_run, output ready);
endinterface
`default_nettype wire

/* sv/cdb_front.sv */
`default_nettype none
module cdb_front (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [2:0]              cfg_index,
    input  wire logic [31:0]             cfg_data,
    cdb_in_if.sink                       in_stream,
    input  wire logic                    q_full,
    output cdb_pkg::q_push_t             q_push
);

    logic [cdb_pkg::WORD_W-1:0]  dict_reg [cdb_pkg::DICT_DEPTH];
    logic [cdb_pkg::BUF_W-1:0]   buf_reg, buf_next;
    logic [cdb_pkg::NBITS_W-1:0] nbits_reg, nbits_next;
    logic                        stop_reg, stop_next;
    logic [cdb_pkg::WORD_W-1:0]  prev_reg, prev_next;
    logic [cdb_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        hold_valid_reg, hold_valid_next;
    cdb_pkg::q_entry_t           hold_reg, hold_next;
    cdb_pkg::fe_state_t          state_reg, state_next;

    cdb_pkg::code_t              code;
    logic [5:0]                  len;
    logic                        avail;
    logic [2:0]                  needed;
    logic                        fits;
    logic                        stall;
    logic                        take;
    logic                        finish;
    logic                        accept;
    logic [cdb_pkg::DICT_IDX_W-1:0] didx;
    logic [cdb_pkg::WORD_W-1:0]  dword;
    logic [cdb_pkg::WORD_W-1:0]  new_word;
    logic [4:0]                  loc;
    logic [cdb_pkg::BUF_W-1:0]   base_buf;
    logic [cdb_pkg::NBITS_W-1:0] base_n;
    logic                        base_stop;

    assign accept = in_stream.valid && in_stream.ready;
    assign in_stream.ready = (state_reg == cdb_pkg::FE_IDLE);

    assign code   = cdb_pkg::code_t'(buf_reg[127:125]);
    assign len    = cdb_pkg::rec_len(code);
    assign avail  = (nbits_reg >= 8'd3) && (nbits_reg >= {2'b00, len});
    assign needed = (code == cdb_pkg::CODE_REPEAT) ? ({1'b0, buf_reg[124:123]} + 3'd1) : 3'd1;
    assign fits   = ({1'b0, cnt_reg} + {3'b000, needed}) <= 6'(cdb_pkg::MAX_RESULTS);
    assign stall  = hold_valid_reg && q_full;
    assign take   = (state_reg == cdb_pkg::FE_DECODE) && !stall && avail
                    && (code != cdb_pkg::CODE_STOP) && fits;
    assign finish = (state_reg == cdb_pkg::FE_DECODE) && !stall && !take;
    assign loc    = buf_reg[124:120];

    always_comb
    begin
        case (code)
            cdb_pkg::CODE_MASK:   didx = buf_reg[115:113];
            cdb_pkg::CODE_FLIP1,
            cdb_pkg::CODE_FLIP_ADJ: didx = buf_reg[119:117];
            cdb_pkg::CODE_FLIP2:  didx = buf_reg[114:112];
            cdb_pkg::CODE_DIRECT: didx = buf_reg[124:122];
            default:              didx = '0;
        endcase
    end

    assign dword = dict_reg[didx];

    always_comb
    begin
        case (code)
            cdb_pkg::CODE_REPEAT:   new_word = prev_reg;
            cdb_pkg::CODE_MASK:     new_word = dword ^ ({buf_reg[119:116], 28'd0} >> loc);
            cdb_pkg::CODE_FLIP1:    new_word = dword ^ cdb_pkg::bit_at(loc);
            cdb_pkg::CODE_FLIP_ADJ:
                new_word = dword ^ cdb_pkg::bit_at(loc)
                           ^ ((loc == 5'd31) ? 32'd0 : cdb_pkg::bit_at(loc + 5'd1));
            cdb_pkg::CODE_FLIP2:
                new_word = dword ^ cdb_pkg::bit_at(loc) ^ cdb_pkg::bit_at(buf_reg[119:115]);
            cdb_pkg::CODE_DIRECT:   new_word = dword;
            cdb_pkg::CODE_RAW:      new_word = buf_reg[124:93];
            default:                new_word = prev_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cdb_pkg::FE_IDLE:
                if (accept && !(stop_reg && !in_stream.start_of_stream))
                    state_next = cdb_pkg::FE_DECODE;
            cdb_pkg::FE_DECODE:
                if (finish)
                    state_next = cdb_pkg::FE_IDLE;
            default: state_next = cdb_pkg::FE_IDLE;
        endcase
    end

    always_comb
    begin
        base_buf  = in_stream.start_of_stream ? '0 : buf_reg;
        base_n    = in_stream.start_of_stream ? '0 : nbits_reg;
        base_stop = in_stream.start_of_stream ? 1'b0 : stop_reg;

        buf_next        = buf_reg;
        nbits_next      = nbits_reg;
        stop_next       = stop_reg;
        prev_next       = prev_reg;
        cnt_next        = cnt_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        q_push          = '0;

        if (accept)
        begin
            buf_next   = base_buf;
            nbits_next = base_n;
            stop_next  = base_stop;
            cnt_next   = '0;
            if (in_stream.start_of_stream)
                prev_next = '0;
            if (!base_stop && (base_n <= 8'd96))
            begin
                buf_next   = base_buf | ({in_stream.stream_word, 96'd0} >> base_n);
                nbits_next = base_n + 8'd32;
            end
        end

        if (take)
        begin
            buf_next        = buf_reg << len;
            nbits_next      = nbits_reg - {2'b00, len};
            cnt_next        = cnt_reg + {2'b00, needed};
            prev_next       = new_word;
            q_push.push     = hold_valid_reg;
            q_push.entry    = hold_reg;
            q_push.entry.last = 1'b0;
            hold_valid_next = 1'b1;
            hold_next.word  = new_word;
            hold_next.reps  = (code == cdb_pkg::CODE_REPEAT) ? buf_reg[124:123] : 2'd0;
            hold_next.last  = 1'b0;
        end

        if (finish)
        begin
            if (avail && (code == cdb_pkg::CODE_STOP))
            begin
                stop_next  = 1'b1;
                buf_next   = '0;
                nbits_next = '0;
            end
            q_push.push       = hold_valid_reg;
            q_push.entry      = hold_reg;
            q_push.entry.last = 1'b1;
            hold_valid_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cdb_pkg::FE_IDLE;
            buf_reg        <= '0;
            nbits_reg      <= '0;
            stop_reg       <= 1'b0;
            prev_reg       <= '0;
            cnt_reg        <= '0;
            hold_valid_reg <= 1'b0;
            for (int i = 0; i < cdb_pkg::DICT_DEPTH; i++)
                dict_reg[i] <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            buf_reg        <= buf_next;
            nbits_reg      <= nbits_next;
            stop_reg       <= stop_next;
            prev_reg       <= prev_next;
            cnt_reg        <= cnt_next;
            hold_valid_reg <= hold_valid_next;
            if (cfg_we)
                dict_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule
`default_nettype wire

/* sv/cdb_fifo.sv */
`default_nettype none
module cdb_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cdb_pkg::q_push_t  q_push,
    output logic                   full,
    output logic                   empty,
    input  wire logic              pop,
    output cdb_pkg::q_entry_t      head
);

    cdb_pkg::q_entry_t            mem_reg [cdb_pkg::Q_DEPTH];
    logic [cdb_pkg::Q_PTR_W-1:0]  wr_reg, wr_next;
    logic [cdb_pkg::Q_PTR_W-1:0]  rd_reg, rd_next;
    logic [cdb_pkg::Q_PTR_W:0]    cnt_reg, cnt_next;
    logic                         do_push;
    logic                         do_pop;

    assign full    = (cnt_reg == (cdb_pkg::Q_PTR_W+1)'(cdb_pkg::Q_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = q_push.push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + {{cdb_pkg::Q_PTR_W{1'b0}}, do_push}
                   - {{cdb_pkg::Q_PTR_W{1'b0}}, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= q_push.entry;
    end

endmodule
`default_nettype wire

/* sv/cdb_back.sv */
`default_nettype none
module cdb_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              empty,
    input  wire cdb_pkg::q_entry_t head,
    output logic                   pop,
    cdb_out_if.source              out_instr
);

    logic                         valid_reg, valid_next;
    logic [cdb_pkg::WORD_W-1:0]   word_reg, word_next;
    logic [1:0]                   rem_reg, rem_next;
    logic                         last_reg, last_next;
    logic                         beat;
    logic                         load;

    assign beat = valid_reg && out_instr.ready;
    assign load = !valid_reg || (beat && (rem_reg == 2'd0));
    assign pop  = load && !empty;

    assign out_instr.valid           = valid_reg;
    assign out_instr.instruction_out = word_reg;
    assign out_instr.last_of_run     = last_reg && (rem_reg == 2'd0);

    always_comb
    begin
        valid_next = valid_reg;
        word_next  = word_reg;
        rem_next   = rem_reg;
        last_next  = last_reg;
        if (beat && (rem_reg != 2'd0))
            rem_next = rem_reg - 2'd1;
        if (load)
        begin
            valid_next = !empty;
            word_next  = head.word;
            rem_next   = head.reps;
            last_next  = head.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rem_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        last_reg <= last_next;
    end

endmodule
`default_nettype wire

/* sv/code_decompressor_bitstream.sv */
`default_nettype none
// Bitmask-dictionary decompressor. Each accepted beat appends 32 stream bits to a 128-bit
// buffer, unless a stop has ended the stream or the buffer holds more than 96 bits; the
// front end then decodes one record per cycle, while the queue has room, into a four-entry
// queue, and the back end emits one instruction per cycle while the output is ready (a
// repeat record emits its word up to four times). A new beat is accepted only when the
// front end has finished decoding the previous one. The eight dictionary words are to be
// written through the cfg port only while the block is idle; the block does not enforce it.
module code_decompressor_bitstream (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    cdb_in_if.sink           in_stream,
    cdb_out_if.source        out_instr
);

    cdb_pkg::q_push_t  q_push;
    cdb_pkg::q_entry_t head;
    logic              q_full;
    logic              q_empty;
    logic              pop;

    cdb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_stream (in_stream),
        .q_full    (q_full),
        .q_push    (q_push)
    );

    cdb_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .full   (q_full),
        .empty  (q_empty),
        .pop    (pop),
        .head   (head)
    );

    cdb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .head      (head),
        .pop       (pop),
        .out_instr (out_instr)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push.push && q_full))
        else $error("queue push while full");

    a_idle_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        in_stream.ready |-> !q_push.push)
        else $error("front end pushed while idle");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !q_empty) |=> out_instr.valid)
        else $error("popped entry not presented");

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`default_nettype none
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] word;
        logic        last;
    } instr_beat_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    cdb_in_if  in_if ();
    cdb_out_if out_if ();

    code_decompressor_bitstream u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_stream (in_if),
        .out_instr (out_if)
    );

    // Decoder state as the block should hold it.
    logic [31:0]  dict_copy [8];
    logic [127:0] pending_bits;
    int unsigned  pending_count;
    logic [31:0]  last_instr;
    logic         halted;

    instr_beat_t  expected_instrs [$];
    int unsigned  error_count;
    int unsigned  send_idle_pct;
    int unsigned  recv_stall_pct;

    // Stream under construction, first bit at the front.
    logic         stream_bits [$];
    logic         next_is_start;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int unsigned record_bits(input cdb_pkg::code_t c);
        case (c)
            cdb_pkg::CODE_REPEAT:   return 5;
            cdb_pkg::CODE_MASK:     return 15;
            cdb_pkg::CODE_FLIP1:    return 11;
            cdb_pkg::CODE_FLIP_ADJ: return 11;
            cdb_pkg::CODE_FLIP2:    return 16;
            cdb_pkg::CODE_DIRECT:   return 6;
            cdb_pkg::CODE_RAW:      return 35;
            default:                return 3;
        endcase
    endfunction

    function automatic logic [31:0] index_bit(input logic [4:0] idx);
        return 32'h8000_0000 >> idx;
    endfunction

    function automatic void decode_beat(input logic [31:0] w, input logic sos);
        cdb_pkg::code_t c;
        int unsigned    len;
        int unsigned    need;
        int unsigned    produced;
        logic [31:0]    rec;
        logic [31:0]    instr;
        logic [4:0]     loc;
        instr_beat_t    b;
        if (sos)
        begin
            pending_bits  = '0;
            pending_count = 0;
            halted        = 1'b0;
            last_instr    = '0;
        end
        if (halted)
            return;
        if (pending_count <= 96)
        begin
            pending_bits  = pending_bits | ({w, 96'b0} >> pending_count);
            pending_count = pending_count + 32;
        end
        produced = 0;
        while (pending_count >= 3)
        begin
            c   = cdb_pkg::code_t'(pending_bits[127:125]);
            len = record_bits(c);
            if (pending_count < len)
                break;
            if (c == cdb_pkg::CODE_STOP)
            begin
                halted        = 1'b1;
                pending_bits  = '0;
                pending_count = 0;
                break;
            end
            rec  = 32'(pending_bits >> (128 - len));
            need = (c == cdb_pkg::CODE_REPEAT) ? rec[1:0] + 1 : 1;
            if (produced + need > cdb_pkg::MAX_RESULTS)
                break;
            instr         = pending_bits[124:93];
            pending_bits  = pending_bits << len;
            pending_count = pending_count - len;
            case (c)
                cdb_pkg::CODE_MASK:
                    instr = dict_copy[rec[2:0]] ^ ({rec[6:3], 28'b0} >> rec[11:7]);
                cdb_pkg::CODE_FLIP1:
                    instr = dict_copy[rec[2:0]] ^ index_bit(rec[7:3]);
                cdb_pkg::CODE_FLIP_ADJ:
                begin
                    loc   = rec[7:3];
                    instr = dict_copy[rec[2:0]] ^ index_bit(loc);
                    if (loc != 5'd31)
                        instr = instr ^ index_bit(loc + 5'd1);
                end
                cdb_pkg::CODE_FLIP2:
                    instr = dict_copy[rec[2:0]] ^ index_bit(rec[12:8])
                            ^ index_bit(rec[7:3]);
                cdb_pkg::CODE_DIRECT:
                    instr = dict_copy[rec[2:0]];
                cdb_pkg::CODE_REPEAT:
                    instr = last_instr;
                default: ;
            endcase
            last_instr = instr;
            for (int i = 0; i < need; i++)
            begin
                b.word = instr;
                b.last = 1'b0;
                expected_instrs.insert(expected_instrs.size(), b);
            end
            produced = produced + need;
        end
        if (produced > 0)
            expected_instrs[expected_instrs.size() - 1].last = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        instr_beat_t exp_b;
        if (!rst_n)
        begin
            out_if.ready <= 1'b0;
        end
        else
        begin
            if (out_if.valid && out_if.ready)
            begin
                if (expected_instrs.size() == 0)
                begin
                    $error("unexpected beat: instruction_out %h", out_if.instruction_out);
                    error_count++;
                end
                else
                begin
                    exp_b = expected_instrs.pop_front();
                    if (out_if.instruction_out !== exp_b.word)
                    begin
                        $error("instruction_out expected %h actual %h",
                               exp_b.word, out_if.instruction_out);
                        error_count++;
                    end
                    if (out_if.last_of_run !== exp_b.last)
                    begin
                        $error("last_of_run expected %b actual %b",
                               exp_b.last, out_if.last_of_run);
                        error_count++;
                    end
                end
            end
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_word(input logic [31:0] w, input logic sos);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid           <= 1'b1;
        in_if.stream_word     <= w;
        in_if.start_of_stream <= sos;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        decode_beat(w, sos);
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_instrs.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic load_dictionary(input logic [31:0] words [8]);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= words[i];
            dict_copy[i] = words[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic push_field(input logic [34:0] v, input int unsigned n);
        for (int i = n - 1; i >= 0; i--)
            stream_bits.insert(stream_bits.size(), v[i]);
    endtask

    task automatic flush_stream();
        logic [31:0] w;
        while (stream_bits.size() >= 32)
        begin
            for (int i = 31; i >= 0; i--)
                w[i] = stream_bits.pop_front();
            send_word(w, next_is_start);
            next_is_start = 1'b0;
        end
    endtask

    // A stop ends the stream: pad to a whole word, send ignored words, restart.
    task automatic end_with_stop(input int unsigned noise_words);
        push_field(35'(cdb_pkg::CODE_STOP), 3);
        while (stream_bits.size() % 32 != 0)
            stream_bits.insert(stream_bits.size(), 1'($urandom_range(1)));
        flush_stream();
        for (int i = 0; i < noise_words; i++)
            send_word($urandom, 1'b0);
        next_is_start = 1'b1;
    endtask

    task automatic add_random_record();
        cdb_pkg::code_t c;
        int unsigned    pick;
        pick = $urandom_range(99);
        if (pick < 3)
            c = cdb_pkg::CODE_STOP;
        else if (pick < 10)
        begin
            push_field(35'($urandom), 32);
            return;
        end
        else
            c = cdb_pkg::code_t'($urandom_range(6));
        case (c)
            cdb_pkg::CODE_REPEAT:   push_field(35'({3'(c), 2'($urandom)}), 5);
            cdb_pkg::CODE_MASK:     push_field(35'({3'(c), 12'($urandom)}), 15);
            cdb_pkg::CODE_FLIP1:    push_field(35'({3'(c), 8'($urandom)}), 11);
            cdb_pkg::CODE_FLIP_ADJ: push_field(35'({3'(c), 8'($urandom)}), 11);
            cdb_pkg::CODE_FLIP2:    push_field(35'({3'(c), 13'($urandom)}), 16);
            cdb_pkg::CODE_DIRECT:   push_field(35'({3'(c), 3'($urandom)}), 6);
            cdb_pkg::CODE_RAW:      push_field({3'(c), 32'($urandom)}, 35);
            default:                end_with_stop($urandom_range(2));
        endcase
    endtask

    task automatic run_random(input int unsigned words, input int unsigned s_pct,
                              input int unsigned r_pct);
        int unsigned target;
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        stream_bits.delete();
        next_is_start = 1'b1;
        repeat (words)
        begin
            target = stream_bits.size() + 32;
            while (stream_bits.size() < target && !next_is_start)
                add_random_record();
            if (next_is_start && stream_bits.size() < 32)
                push_field(35'($urandom), 32);
            flush_stream();
        end
        settle();
    endtask

    task automatic test_directed();
        logic [31:0] d [8];
        d = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0001, 32'h1234_5678,
              32'hAAAA_5555, 32'h0F0F_F0F0, 32'h7FFF_FFFE, 32'hDEAD_BEEF};
        load_dictionary(d);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        stream_bits.delete();
        next_is_start = 1'b1;
        push_field(35'({3'(cdb_pkg::CODE_REPEAT), 2'd1}), 5);
        push_field(35'({3'(cdb_pkg::CODE_MASK), 5'd0, 4'hF, 3'd1}), 15);
        push_field(35'({3'(cdb_pkg::CODE_MASK), 5'd30, 4'hF, 3'd0}), 15);
        push_field(35'({3'(cdb_pkg::CODE_MASK), 5'd31, 4'h8, 3'd1}), 15);
        push_field(35'({3'(cdb_pkg::CODE_FLIP1), 5'd0, 3'd0}), 11);
        push_field(35'({3'(cdb_pkg::CODE_FLIP1), 5'd31, 3'd1}), 11);
        push_field(35'({3'(cdb_pkg::CODE_FLIP_ADJ), 5'd0, 3'd2}), 11);
        push_field(35'({3'(cdb_pkg::CODE_FLIP_ADJ), 5'd31, 3'd0}), 11);
        push_field(35'({3'(cdb_pkg::CODE_FLIP2), 5'd5, 5'd5, 3'd3}), 16);
        push_field(35'({3'(cdb_pkg::CODE_FLIP2), 5'd0, 5'd31, 3'd4}), 16);
        for (int i = 0; i < 8; i++)
            push_field(35'({3'(cdb_pkg::CODE_DIRECT), 3'(i)}), 6);
        push_field({3'(cdb_pkg::CODE_RAW), 32'hFFFF_FFFF}, 35);
        push_field({3'(cdb_pkg::CODE_RAW), 32'h0000_0000}, 35);
        for (int i = 0; i < 40; i++)
            push_field(35'({3'(cdb_pkg::CODE_REPEAT), 2'd3}), 5);
        end_with_stop(2);
        push_field(35'({3'(cdb_pkg::CODE_REPEAT), 2'd0}), 5);
        push_field(35'({3'(cdb_pkg::CODE_DIRECT), 3'd7}), 6);
        while (stream_bits.size() % 32 != 0)
            push_field(35'({3'(cdb_pkg::CODE_REPEAT), 2'd0}), 5);
        flush_stream();
        settle();
    endtask

    task automatic test_dictionary_settings();
        logic [31:0] d [8];
        for (int i = 0; i < 8; i++)
            d[i] = '1;
        load_dictionary(d);
        run_random(20, 0, 0);
        for (int i = 0; i < 8; i++)
            d[i] = $urandom;
        load_dictionary(d);
        run_random(20, 0, 0);
    endtask

    task automatic test_idling();
        run_random(35, 87, 0);
        run_random(35, 0, 87);
        run_random(35, 12, 12);
        run_random(30, 0, 0);
    endtask

    task automatic test_sender_pause();
        send_idle_pct  = 12;
        recv_stall_pct = 50;
        stream_bits.delete();
        next_is_start = 1'b1;
        for (int i = 0; i < 16; i++)
            add_random_record();
        flush_stream();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_instrs.size() != 0)
            @(posedge clk);
        for (int i = 0; i < 16; i++)
            add_random_record();
        flush_stream();
        settle();
    endtask

    initial
    begin
        error_count           = 0;
        send_idle_pct         = 0;
        recv_stall_pct        = 0;
        next_is_start         = 1'b1;
        dict_copy             = '{default: '0};
        pending_bits          = '0;
        pending_count         = 0;
        last_instr            = '0;
        halted                = 1'b0;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        in_if.valid           = 1'b0;
        in_if.stream_word     = '0;
        in_if.start_of_stream = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_dictionary_settings();
        test_idling();
        test_sender_pause();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
sv/cdb_pkg.sv
sv/cdb_intf.sv
sv/cdb_front.sv
sv/cdb_fifo.sv
sv/cdb_back.sv
sv/code_decompressor_bitstream.sv
tb/sv/tb.sv
